@@ src/tfd_pkg.sv @@
// ----------------------------------------------------------------------------
// tfd_pkg
// Shared types, constants and the CRC-8 byte step for the frame deframer.
// ----------------------------------------------------------------------------
package tfd_pkg;

	localparam int FRAME_LEN = 25;
	localparam int CRC_LEN   = 24;
	localparam int IDX_W     = $clog2(FRAME_LEN);

	localparam logic [7:0] SYNC_A   = 8'hA5;
	localparam logic [7:0] SYNC_B   = 8'hEC;
	localparam logic [7:0] CRC_POLY = 8'h07;

	localparam logic [16:0] TIME_THRESH = 17'd32768;
	localparam logic [4:0]  SEQ_THRESH  = 5'd8;

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic [7:0] rx_byte;
	} rx_word_t;

	typedef struct packed {
		logic        [31:0] time_extended;
		logic signed [15:0] pos_north;
		logic signed [15:0] pos_east;
		logic signed [15:0] pos_down;
		logic signed [15:0] vel_down;
		logic signed [15:0] acc_down_raw;
		logic        [63:0] quat_packed;
		logic        [2:0]  flight_state;
		logic        [2:0]  sensor_status;
		logic        [1:0]  ejection_kind;
		logic        [15:0] rx_seq_extended;
		logic        [15:0] tx_seq_extended;
	} frame_t;

	typedef struct packed {
		logic shift;
		logic crc_clr;
		logic crc_step;
		idx_t idx;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic frame_ok;
		logic out_free;
	} dp_status_t;

	// CRC-8, MSB first, one byte folded in
	function automatic logic [7:0] crc8_byte(input logic [7:0] c_in);
		logic [7:0] c;
		c = c_in;
		for (int b = 0; b < 8; b++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

@@ src/tfd_stream_if.sv @@
// ----------------------------------------------------------------------------
// tfd_stream_if
// Valid/ready word channel with a typed payload.
// ----------------------------------------------------------------------------
interface tfd_stream_if #(
	parameter type payload_t = logic [7:0]
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

@@ src/tfd_datapath.sv @@
// ----------------------------------------------------------------------------
// tfd_datapath
// Byte window shift line, serial CRC accumulator, frame decode, wrap
// trackers and the output word register.
// ----------------------------------------------------------------------------
module tfd_datapath #(
	parameter int TIME_WRAP_BITS = 16,
	parameter int SEQ_WRAP_BITS  = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tfd_pkg::dp_cmd_t     cmd,
	output tfd_pkg::dp_status_t  status,
	input  tfd_pkg::rx_word_t    rx_word,
	output logic                 out_valid,
	input  logic                 out_ready,
	output tfd_pkg::frame_t      out_word
);

	localparam int TIME_ALL_W = TIME_WRAP_BITS + 16;
	localparam int TIME_EXT_W = (TIME_ALL_W > 32) ? TIME_ALL_W : 32;
	localparam int SEQ_ALL_W  = SEQ_WRAP_BITS + 4;
	localparam int SEQ_EXT_W  = (SEQ_ALL_W > 16) ? SEQ_ALL_W : 16;

	logic [7:0] win_q [tfd_pkg::FRAME_LEN];
	logic [7:0] crc_q;
	logic       out_valid_q;
	tfd_pkg::frame_t out_q;

	logic [15:0]               last_time_q;
	logic                      time_seen_q;
	logic [TIME_WRAP_BITS-1:0] time_wraps_q;
	logic [3:0]                last_rx_q;
	logic                      rx_seen_q;
	logic [SEQ_WRAP_BITS-1:0]  rx_wraps_q;
	logic [3:0]                last_tx_q;
	logic                      tx_seen_q;
	logic [SEQ_WRAP_BITS-1:0]  tx_wraps_q;

	logic [15:0]               t_raw;
	logic [3:0]                rx_raw;
	logic [3:0]                tx_raw;
	logic [TIME_WRAP_BITS-1:0] time_wraps_nx;
	logic [SEQ_WRAP_BITS-1:0]  rx_wraps_nx;
	logic [SEQ_WRAP_BITS-1:0]  tx_wraps_nx;
	logic [TIME_EXT_W-1:0]     time_wide;
	logic [SEQ_EXT_W-1:0]      rx_wide;
	logic [SEQ_EXT_W-1:0]      tx_wide;
	tfd_pkg::frame_t           dec;

	assign t_raw  = {win_q[3], win_q[2]};
	assign rx_raw = win_q[23][3:0];
	assign tx_raw = win_q[23][7:4];

	assign time_wraps_nx = (time_seen_q && ({1'b0, last_time_q} > ({1'b0, t_raw} +
		tfd_pkg::TIME_THRESH))) ? time_wraps_q + TIME_WRAP_BITS'(1) : time_wraps_q;
	assign rx_wraps_nx = (rx_seen_q && ({1'b0, last_rx_q} > ({1'b0, rx_raw} +
		tfd_pkg::SEQ_THRESH))) ? rx_wraps_q + SEQ_WRAP_BITS'(1) : rx_wraps_q;
	assign tx_wraps_nx = (tx_seen_q && ({1'b0, last_tx_q} > ({1'b0, tx_raw} +
		tfd_pkg::SEQ_THRESH))) ? tx_wraps_q + SEQ_WRAP_BITS'(1) : tx_wraps_q;

	assign time_wide = TIME_EXT_W'({time_wraps_nx, t_raw});
	assign rx_wide   = SEQ_EXT_W'({rx_wraps_nx, rx_raw});
	assign tx_wide   = SEQ_EXT_W'({tx_wraps_nx, tx_raw});

	always_comb begin
		dec.time_extended   = time_wide[31:0];
		dec.pos_north       = {win_q[5], win_q[4]};
		dec.pos_east        = {win_q[7], win_q[6]};
		dec.pos_down        = {win_q[9], win_q[8]};
		dec.vel_down        = {win_q[11], win_q[10]};
		dec.acc_down_raw    = {win_q[13], win_q[12]};
		dec.quat_packed     = {win_q[21], win_q[20], win_q[19], win_q[18],
		                       win_q[17], win_q[16], win_q[15], win_q[14]};
		dec.flight_state    = win_q[22][2:0];
		dec.sensor_status   = win_q[22][5:3];
		dec.ejection_kind   = win_q[22][7:6];
		dec.rx_seq_extended = rx_wide[15:0];
		dec.tx_seq_extended = tx_wide[15:0];
	end

	assign status.frame_ok = (win_q[0] == tfd_pkg::SYNC_A) && (win_q[1] == tfd_pkg::SYNC_B)
		&& (crc_q == win_q[tfd_pkg::CRC_LEN]);
	assign status.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	// oldest byte at index 0, newest enters at the top
	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			for (int i = 0; i < tfd_pkg::FRAME_LEN - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[tfd_pkg::FRAME_LEN-1] <= rx_word.rx_byte;
		end
		if (cmd.emit) begin
			out_q <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q        <= '0;
			out_valid_q  <= 1'b0;
			last_time_q  <= '0;
			time_seen_q  <= 1'b0;
			time_wraps_q <= '0;
			last_rx_q    <= '0;
			rx_seen_q    <= 1'b0;
			rx_wraps_q   <= '0;
			last_tx_q    <= '0;
			tx_seen_q    <= 1'b0;
			tx_wraps_q   <= '0;
		end else begin
			if (cmd.crc_clr) begin
				crc_q <= '0;
			end else if (cmd.crc_step) begin
				crc_q <= tfd_pkg::crc8_byte(crc_q ^ win_q[cmd.idx]);
			end
			if (cmd.emit) begin
				out_valid_q  <= 1'b1;
				last_time_q  <= t_raw;
				time_seen_q  <= 1'b1;
				time_wraps_q <= time_wraps_nx;
				last_rx_q    <= rx_raw;
				rx_seen_q    <= 1'b1;
				rx_wraps_q   <= rx_wraps_nx;
				last_tx_q    <= tx_raw;
				tx_seen_q    <= 1'b1;
				tx_wraps_q   <= tx_wraps_nx;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ src/tfd_ctrl.sv @@
// ----------------------------------------------------------------------------
// tfd_ctrl
// Sequencer: tracks window fill, steps the CRC over the window, decides
// between frame emit and dropping the oldest byte.
// ----------------------------------------------------------------------------
module tfd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rx_valid,
	output logic                rx_ready,
	output tfd_pkg::dp_cmd_t    cmd,
	input  tfd_pkg::dp_status_t status
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_EVAL,
		S_EMIT
	} state_t;

	localparam tfd_pkg::idx_t FILL_LAST = tfd_pkg::idx_t'(tfd_pkg::FRAME_LEN - 1);
	localparam tfd_pkg::idx_t CNT_LAST  = tfd_pkg::idx_t'(tfd_pkg::CRC_LEN - 1);

	state_t        state_q;
	tfd_pkg::idx_t fill_q;
	tfd_pkg::idx_t cnt_q;
	logic          accept;

	assign rx_ready = (state_q == S_IDLE);
	assign accept   = rx_valid && rx_ready;

	assign cmd.shift    = accept;
	assign cmd.crc_clr  = accept;
	assign cmd.crc_step = (state_q == S_CHECK);
	assign cmd.idx      = cnt_q;
	assign cmd.emit     = (state_q == S_EMIT) && status.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (rx_valid) begin
						if (fill_q == FILL_LAST) begin
							state_q <= S_CHECK;
							cnt_q   <= '0;
						end else begin
							fill_q <= fill_q + 1'b1;
						end
					end
				end
				S_CHECK: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					state_q <= status.frame_ok ? S_EMIT : S_IDLE;
				end
				S_EMIT: begin
					if (status.out_free) begin
						fill_q  <= '0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_LAST)
		else $error("window fill beyond frame length");

	a_full_starts_check: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && fill_q == FILL_LAST) |=> (state_q == S_CHECK && cnt_q == '0))
		else $error("full window did not start a check");

	a_bad_frame_keeps_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EVAL && !status.frame_ok) |=> (state_q == S_IDLE && fill_q == FILL_LAST))
		else $error("rejected window not trimmed to frame length minus one");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (fill_q == '0 && state_q == S_IDLE))
		else $error("emitted frame did not clear the window");

	a_check_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK) |-> (fill_q == FILL_LAST))
		else $error("check running on a partial window");

endmodule

@@ src/telemetry_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// telemetry_frame_deframer
// Sync-word / CRC-8 telemetry frame finder and decoder.
// ----------------------------------------------------------------------------
// Channels: rx takes one stream byte per word; frm gives one decoded frame
// per word. Both use valid/ready, a word moves when both are high.
// Bytes fill a 25-byte window. While it is filling, a byte is taken
// whenever rx.valid is high. A byte that completes the window starts a
// check: the CRC-8 is folded in one byte per cycle over 24 bytes, then
// the S_EVAL state decides, and rx.ready stays low through the check and
// the decision. With a valid frame the S_EMIT state loads the output
// register once it is free, and frm.valid then rises.
// A finished frame sits in the output register while the next bytes are
// taken; only when a further frame is ready and frm is still stalled does
// the block hold rx.ready low until frm.ready frees the register.
// Reset empties the window, clears the output valid flag and restarts the
// timestamp and sequence wrap counters.
// ----------------------------------------------------------------------------
module telemetry_frame_deframer #(
	parameter int TIME_WRAP_BITS = 16,
	parameter int SEQ_WRAP_BITS  = 12
) (
	input  logic         clk,
	input  logic         arst_n,
	tfd_stream_if.sink   rx,
	tfd_stream_if.source frm
);

	tfd_pkg::dp_cmd_t    cmd;
	tfd_pkg::dp_status_t status;

	tfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx.valid),
		.rx_ready (rx.ready),
		.cmd      (cmd),
		.status   (status)
	);

	tfd_datapath #(
		.TIME_WRAP_BITS (TIME_WRAP_BITS),
		.SEQ_WRAP_BITS  (SEQ_WRAP_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.rx_word   (rx.payload),
		.out_valid (frm.valid),
		.out_ready (frm.ready),
		.out_word  (frm.payload)
	);

endmodule

@@ verif/telemetry_frame_deframer_checker.sv @@
// ----------------------------------------------------------------------------
// telemetry_frame_deframer_checker
// Watches the byte and frame channels of the deframer. Every accepted byte is
// pushed through a local model of the window search, CRC-8 check and field
// decode; each decoded frame is queued and compared field by field with the
// next frame the block hands out. Failures and the number of frames still
// outstanding go to the testbench top.
// ----------------------------------------------------------------------------
module telemetry_frame_deframer_checker (
	input  logic  clk,
	input  logic  arst_n,
	tfd_stream_if rx_mon,
	tfd_stream_if frm_mon,
	output int    fail_count,
	output int    frames_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [7:0]       win [tfd_pkg::FRAME_LEN];
	int               win_fill;
	logic [15:0]      prev_time;
	logic             time_known;
	logic [15:0]      time_wraps;
	logic [3:0]       prev_rx;
	logic [3:0]       prev_tx;
	logic             rx_known;
	logic             tx_known;
	logic [11:0]      rx_wraps;
	logic [11:0]      tx_wraps;
	tfd_pkg::frame_t  expected_frames [$];
	int               mismatches;

	function automatic logic [7:0] window_crc8();
		logic [7:0] c;
		c = 8'h00;
		for (int i = 0; i < tfd_pkg::CRC_LEN; i++) begin
			c = c ^ win[i];
			for (int b = 0; b < 8; b++) begin
				if (c[7]) begin
					c = {c[6:0], 1'b0} ^ tfd_pkg::CRC_POLY;
				end else begin
					c = {c[6:0], 1'b0};
				end
			end
		end
		return c;
	endfunction

	task automatic decode_window(output tfd_pkg::frame_t f);
		logic [15:0] t;
		logic [3:0]  rs;
		logic [3:0]  ts;
		t  = {win[3], win[2]};
		rs = win[23][3:0];
		ts = win[23][7:4];
		// no wrap is counted on the first sighting of a counter
		if (time_known && int'(prev_time) > int'(t) + int'(tfd_pkg::TIME_THRESH))
			time_wraps++;
		if (rx_known && int'(prev_rx) > int'(rs) + int'(tfd_pkg::SEQ_THRESH)) rx_wraps++;
		if (tx_known && int'(prev_tx) > int'(ts) + int'(tfd_pkg::SEQ_THRESH)) tx_wraps++;
		time_known = 1'b1;
		rx_known   = 1'b1;
		tx_known   = 1'b1;
		prev_time  = t;
		prev_rx    = rs;
		prev_tx    = ts;
		f.time_extended   = {time_wraps, t};
		f.pos_north       = {win[5], win[4]};
		f.pos_east        = {win[7], win[6]};
		f.pos_down        = {win[9], win[8]};
		f.vel_down        = {win[11], win[10]};
		f.acc_down_raw    = {win[13], win[12]};
		f.quat_packed     = {win[21], win[20], win[19], win[18],
		                     win[17], win[16], win[15], win[14]};
		f.flight_state    = win[22][2:0];
		f.sensor_status   = win[22][5:3];
		f.ejection_kind   = win[22][7:6];
		f.rx_seq_extended = {rx_wraps, rs};
		f.tx_seq_extended = {tx_wraps, ts};
	endtask

	task automatic absorb_byte(input logic [7:0] b);
		tfd_pkg::frame_t f;
		win[win_fill] = b;
		win_fill++;
		if (win_fill == tfd_pkg::FRAME_LEN) begin
			if (win[0] == tfd_pkg::SYNC_A && win[1] == tfd_pkg::SYNC_B &&
			    window_crc8() == win[tfd_pkg::CRC_LEN]) begin
				decode_window(f);
				expected_frames = {expected_frames, f};
				win_fill = 0;
			end else begin
				for (int i = 0; i < tfd_pkg::FRAME_LEN - 1; i++) win[i] = win[i + 1];
				win_fill = tfd_pkg::FRAME_LEN - 1;
			end
		end
	endtask

	function automatic void show_field(string fname, logic [63:0] want, logic [63:0] got);
		if (want !== got) $display("  %s: expected %h, got %h", fname, want, got);
	endfunction

	task automatic check_frame(input tfd_pkg::frame_t got);
		tfd_pkg::frame_t want;
		if (expected_frames.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: frame with none expected, time_extended %h",
				         $time, got.time_extended);
		end else begin
			want = expected_frames[0];
			expected_frames.delete(0);
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: frame mismatch", $time);
					show_field("time_extended", want.time_extended, got.time_extended);
					show_field("pos_north", want.pos_north, got.pos_north);
					show_field("pos_east", want.pos_east, got.pos_east);
					show_field("pos_down", want.pos_down, got.pos_down);
					show_field("vel_down", want.vel_down, got.vel_down);
					show_field("acc_down_raw", want.acc_down_raw, got.acc_down_raw);
					show_field("quat_packed", want.quat_packed, got.quat_packed);
					show_field("flight_state", want.flight_state, got.flight_state);
					show_field("sensor_status", want.sensor_status, got.sensor_status);
					show_field("ejection_kind", want.ejection_kind, got.ejection_kind);
					show_field("rx_seq_extended", want.rx_seq_extended, got.rx_seq_extended);
					show_field("tx_seq_extended", want.tx_seq_extended, got.tx_seq_extended);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_fill   = 0;
			prev_time  = '0;
			time_known = 1'b0;
			time_wraps = '0;
			prev_rx    = '0;
			prev_tx    = '0;
			rx_known   = 1'b0;
			tx_known   = 1'b0;
			rx_wraps   = '0;
			tx_wraps   = '0;
			mismatches = 0;
			expected_frames.delete();
			fail_count     <= 0;
			frames_pending <= 0;
		end else begin
			if (frm_mon.valid && frm_mon.ready) check_frame(frm_mon.payload);
			if (rx_mon.valid && rx_mon.ready) absorb_byte(rx_mon.payload.rx_byte);
			fail_count     <= mismatches;
			frames_pending <= expected_frames.size();
		end
	end

endmodule

@@ verif/telemetry_frame_deframer_tb.sv @@
// ----------------------------------------------------------------------------
// telemetry_frame_deframer_tb
// Feeds the deframer a byte stream of well-formed frames, frames with a
// flipped bit, cut-off frames and loose noise, starting with hand-picked
// frames for the field extremes and the wrap thresholds. Both channels idle
// at random in the first two of three phases; the checker beside the block judges the frames.
// ----------------------------------------------------------------------------
module telemetry_frame_deframer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_BYTES = 1500;
	localparam int TAIL_CYCLES  = 40;

	typedef enum int {
		FILL_RANDOM,
		FILL_ZERO,
		FILL_ONES,
		FILL_MIN,
		FILL_MAX
	} fill_t;

	logic        clk;
	logic        arst_n;
	logic        rcv_ready   = 1'b0;
	int          tx_idle_pct = 0;
	int          rx_idle_pct = 0;
	int          cycle_count = 0;
	int          bytes_sent  = 0;
	int          fail_count;
	int          frames_pending;
	logic [15:0] gen_time;
	logic [3:0]  gen_rx;
	logic [3:0]  gen_tx;

	tfd_stream_if #(.payload_t(tfd_pkg::rx_word_t)) rx_if ();
	tfd_stream_if #(.payload_t(tfd_pkg::frame_t))   frm_if ();

	assign frm_if.ready = rcv_ready;

	telemetry_frame_deframer uut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.frm    (frm_if)
	);

	telemetry_frame_deframer_checker chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.rx_mon         (rx_if),
		.frm_mon        (frm_if),
		.fail_count     (fail_count),
		.frames_pending (frames_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		rcv_ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic logic [7:0] frame_crc8(input logic [7:0] fb [tfd_pkg::FRAME_LEN]);
		logic [7:0] c;
		c = 8'h00;
		for (int i = 0; i < tfd_pkg::CRC_LEN; i++) begin
			c = c ^ fb[i];
			for (int b = 0; b < 8; b++) begin
				c = c[7] ? ({c[6:0], 1'b0} ^ tfd_pkg::CRC_POLY) : {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < tx_idle_pct) begin
			rx_if.valid <= 1'b0;
			@(posedge clk);
		end
		rx_if.valid   <= 1'b1;
		rx_if.payload <= tfd_pkg::rx_word_t'(b);
		@(posedge clk);
		while (!rx_if.ready) @(posedge clk);
		bytes_sent++;
	endtask

	// flip_at < 0: intact; a sync byte is flipped under a good CRC
	task automatic send_frame(input logic [15:0] t, input logic [3:0] rs,
	                          input logic [3:0] ts, input fill_t fill,
	                          input int flip_at, input int cut_len);
		logic [7:0] fb [tfd_pkg::FRAME_LEN];
		logic [7:0] flip_mask;
		flip_mask = 8'h01 << $urandom_range(7);
		for (int i = 0; i < tfd_pkg::FRAME_LEN; i++) begin
			case (fill)
				FILL_ZERO: fb[i] = 8'h00;
				FILL_ONES: fb[i] = 8'hFF;
				FILL_MIN:  fb[i] = i[0] ? 8'h80 : 8'h00;
				FILL_MAX:  fb[i] = i[0] ? 8'h7F : 8'hFF;
				default:   fb[i] = 8'($urandom);
			endcase
		end
		fb[0]  = tfd_pkg::SYNC_A;
		fb[1]  = tfd_pkg::SYNC_B;
		fb[2]  = t[7:0];
		fb[3]  = t[15:8];
		fb[23] = {ts, rs};
		if (flip_at == 0 || flip_at == 1) fb[flip_at] = fb[flip_at] ^ flip_mask;
		fb[tfd_pkg::CRC_LEN] = frame_crc8(fb);
		if (flip_at >= 2) fb[flip_at] = fb[flip_at] ^ flip_mask;
		for (int i = 0; i < cut_len; i++) send_byte(fb[i]);
	endtask

	task automatic wait_for_frames();
		rx_if.valid <= 1'b0;
		@(posedge clk);
		while (frames_pending != 0) @(posedge clk);
	endtask

	initial begin
		int pick;
		int stop_at;
		arst_n        <= 1'b0;
		rx_if.valid   <= 1'b0;
		rx_if.payload <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 27;
		rx_idle_pct = 63;
		send_byte(8'h00);
		send_byte(tfd_pkg::SYNC_A);
		// first frame, then timestamp and sequence steps at and past the thresholds
		send_frame(16'hFFFF, 4'hF, 4'h0, FILL_ONES, -1, tfd_pkg::FRAME_LEN);
		send_frame(16'h7FFF, 4'h7, 4'h0, FILL_ZERO, -1, tfd_pkg::FRAME_LEN);
		send_frame(16'hFFFF, 4'hF, 4'hF, FILL_MIN, -1, tfd_pkg::FRAME_LEN);
		send_frame(16'h7FFE, 4'h6, 4'h6, FILL_MAX, -1, tfd_pkg::FRAME_LEN);
		send_frame(16'h0000, 4'h0, 4'h0, FILL_RANDOM, tfd_pkg::CRC_LEN, tfd_pkg::FRAME_LEN);
		send_frame(16'h0001, 4'h1, 4'h1, FILL_RANDOM, 1, tfd_pkg::FRAME_LEN);
		send_frame(16'h0002, 4'h2, 4'h2, FILL_RANDOM, -1, tfd_pkg::FRAME_LEN);
		wait_for_frames();

		gen_time = 16'h0002;
		gen_rx   = 4'h2;
		gen_tx   = 4'h2;
		for (int phase = 0; phase < 3; phase++) begin
			tx_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 63 : 0;
			rx_idle_pct = (phase == 0) ? 63 : (phase == 1) ? 27 : 0;
			stop_at = bytes_sent + RANDOM_BYTES / 3;
			while (bytes_sent < stop_at) begin
				case ($urandom_range(9))
					0, 1, 2, 3, 4, 5: gen_time = gen_time + 16'($urandom_range(1, 300));
					6:       gen_time = gen_time + 16'($urandom_range(30000, 40000));
					7:       gen_time = gen_time - 16'($urandom_range(32766, 32770));
					8:       gen_time = 16'($urandom);
					default: ;
				endcase
				case ($urandom_range(5))
					0, 1, 2: gen_rx = gen_rx + 4'd1;
					3:       gen_rx = gen_rx - 4'($urandom_range(8, 9));
					4:       gen_rx = 4'($urandom);
					default: ;
				endcase
				case ($urandom_range(5))
					0, 1, 2: gen_tx = gen_tx + 4'd1;
					3:       gen_tx = gen_tx - 4'($urandom_range(8, 9));
					4:       gen_tx = 4'($urandom);
					default: ;
				endcase
				pick = $urandom_range(99);
				if (pick < 70) begin
					send_frame(gen_time, gen_rx, gen_tx, FILL_RANDOM, -1, tfd_pkg::FRAME_LEN);
				end else if (pick < 80) begin
					send_frame(gen_time, gen_rx, gen_tx, FILL_RANDOM,
					           $urandom_range(tfd_pkg::FRAME_LEN - 1), tfd_pkg::FRAME_LEN);
				end else if (pick < 88) begin
					send_frame(gen_time, gen_rx, gen_tx, FILL_RANDOM, -1,
					           $urandom_range(1, tfd_pkg::FRAME_LEN - 1));
				end else begin
					repeat ($urandom_range(1, 12))
						send_byte(($urandom_range(3) == 0) ? tfd_pkg::SYNC_A : 8'($urandom));
				end
			end
			wait_for_frames();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && frames_pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
